// ===== rtl/core/ptb_pkg.sv =====
// Shared types and constants of the periodic timer bank.
`timescale 1ns / 1ps

package ptb_pkg;

   // Default number of timer channels.
   localparam int CHANNELS_DEFAULT = 8;

   // Field widths.
   localparam int CMD_W   = 2;
   localparam int CHAN_W  = 3;
   localparam int TIME_W  = 16;
   localparam int TICK_W  = 16;
   localparam int MASK_W  = 8;

   // Saturation limit of a channel's tick backlog.
   localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

   // The divider retires one quotient bit per cycle.
   localparam int DIV_STEPS = TIME_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Command codes.
   typedef enum logic [CMD_W-1:0] {
      OP_STEP  = 2'd0,
      OP_START = 2'd1,
      OP_STOP  = 2'd2,
      OP_POLL  = 2'd3
   } ptb_op_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;
      logic eval;
      logic div_step;
      logic fix;
      logic advance;
      logic finish;
   } ptb_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic needs_div;
      logic div_last;
      logic last_chan;
   } ptb_status_type;

endpackage

// ===== rtl/core/ptb_req_if.sv =====
// Request channel interface of the periodic timer bank.
`timescale 1ns / 1ps

interface ptb_req_if;
   logic                          valid;
   logic                          ready;
   logic [ptb_pkg::CMD_W-1:0]     command;
   logic [ptb_pkg::CHAN_W-1:0]    channel;
   logic [ptb_pkg::TIME_W-1:0]    interval_ms;
   logic [ptb_pkg::TIME_W-1:0]    elapsed_ms;

   modport source (output valid, command, channel, interval_ms, elapsed_ms, input ready);
   modport sink (input valid, command, channel, interval_ms, elapsed_ms, output ready);
endinterface

// ===== rtl/core/ptb_rsp_if.sv =====
// Response channel interface of the periodic timer bank.
`timescale 1ns / 1ps

interface ptb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ptb_pkg::MASK_W-1:0]    due_mask;
   logic [ptb_pkg::TIME_W-1:0]    next_delay_ms;
   logic                          no_deadline;
   logic [ptb_pkg::TICK_W-1:0]    pending_ticks;
   logic                          channel_running;

   modport source (output valid, due_mask, next_delay_ms, no_deadline, pending_ticks,
                   channel_running, input ready);
   modport sink (input valid, due_mask, next_delay_ms, no_deadline, pending_ticks,
                 channel_running, output ready);
endinterface

// ===== rtl/core/ptb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ptb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ptb_ctrl.sv =====
// Sequencing state machine of the periodic timer bank.
`timescale 1ns / 1ps

module ptb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  ptb_pkg::ptb_status_type status,
   output ptb_pkg::ptb_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_READ = 6'b000010,
      ST_EVAL = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_FIX  = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The result register can take a new result when empty or draining.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (status.needs_div) begin
               state_in = ST_DIV;
            end else if (status.last_chan) begin
               state_in = ST_DONE;
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            cmd.fix = 1'b1;
            if (status.last_chan) begin
               state_in = ST_DONE;
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid flag: set on finish, cleared by a transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The divider always runs to completion and then fixes up the channel.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |=> state_ff == ST_DIV || state_ff == ST_FIX)
      else $error("divider left early");

   // A result is never overwritten while it still waits for a transfer.
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !rsp_valid_ff || rsp_ready)
      else $error("pending result overwritten");

endmodule

// ===== rtl/core/ptb_dp.sv =====
// Datapath of the periodic timer bank: channel stores, sweep, divider and result.
`timescale 1ns / 1ps

module ptb_dp #(
   parameter int CHANNELS = ptb_pkg::CHANNELS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ptb_pkg::ptb_cmd_type          cmd,
   output ptb_pkg::ptb_status_type       status,
   input  logic [ptb_pkg::CMD_W-1:0]     req_command,
   input  logic [ptb_pkg::CHAN_W-1:0]    req_channel,
   input  logic [ptb_pkg::TIME_W-1:0]    req_interval_ms,
   input  logic [ptb_pkg::TIME_W-1:0]    req_elapsed_ms,
   output logic [ptb_pkg::MASK_W-1:0]    rsp_due_mask,
   output logic [ptb_pkg::TIME_W-1:0]    rsp_next_delay_ms,
   output logic                          rsp_no_deadline,
   output logic [ptb_pkg::TICK_W-1:0]    rsp_pending_ticks,
   output logic                          rsp_channel_running
);

   localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CMP_W  = (IDX_W > ptb_pkg::CHAN_W) ? IDX_W : ptb_pkg::CHAN_W;
   localparam int TW     = ptb_pkg::TIME_W;
   localparam int KW     = ptb_pkg::TICK_W;

   // Captured request.
   ptb_pkg::ptb_op_type        op_ff, op_in;
   logic [ptb_pkg::CHAN_W-1:0] ch_ff, ch_in;
   logic [TW-1:0]              iv_ff, iv_in;
   logic [TW-1:0]              el_ff, el_in;

   // Sweep index and per-channel flags.
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [CHANNELS-1:0] run_ff, run_in;
   logic [CHANNELS-1:0] skip_ff, skip_in;
   logic [CHANNELS-1:0] bval_ff, bval_in;

   // Accumulated result of the sweep.
   logic [ptb_pkg::MASK_W-1:0] due_ff, due_in;
   logic                       any_ff, any_in;
   logic [TW-1:0]              best_ff, best_in;
   logic [KW-1:0]              drained_ff, drained_in;
   logic                       chrun_ff, chrun_in;

   // Divider.
   logic [TW-1:0]                 q_ff, q_in;
   logic [TW:0]                   r_ff, r_in;
   logic [TW-1:0]                 d_ff, d_in;
   logic [ptb_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [KW-1:0]                 blog_hold_ff, blog_hold_in;

   // Output registers.
   logic [ptb_pkg::MASK_W-1:0] o_due_ff;
   logic [TW-1:0]              o_delay_ff;
   logic                       o_nodl_ff;
   logic [KW-1:0]              o_ticks_ff;
   logic                       o_run_ff;

   // Store ports.
   logic [TW-1:0] rem_rd, per_rd;
   logic [KW-1:0] blog_rd;
   logic          rem_we, per_we, blog_we;
   logic [TW-1:0] rem_wd, per_wd;
   logic [KW-1:0] blog_wd;

   // Per-channel evaluation.
   logic          hit, run_cur, skip_cur, is_step, step_run, nonpos;
   logic          is_start, is_stop, is_poll, run_after;
   logic [KW-1:0] blog_cur;
   logic [TW:0]   rem_sub, rem_neg;
   logic [TW-1:0] iv_eff, rem_after, rem_fix;
   logic [TW:0]   div_trial, div_diff;
   logic [KW:0]   k_val;
   logic [KW+1:0] tick_sum;
   logic [KW-1:0] tick_sat;
   logic          min_en;
   logic [TW-1:0] min_val;

   ptb_ram #(.WIDTH(TW), .DEPTH(CHANNELS)) u_rem_ram (
      .clock   (clock),
      .wr_en   (rem_we),
      .wr_addr (idx_ff),
      .wr_data (rem_wd),
      .rd_addr (idx_ff),
      .rd_data (rem_rd)
   );

   ptb_ram #(.WIDTH(TW), .DEPTH(CHANNELS)) u_per_ram (
      .clock   (clock),
      .wr_en   (per_we),
      .wr_addr (idx_ff),
      .wr_data (per_wd),
      .rd_addr (idx_ff),
      .rd_data (per_rd)
   );

   ptb_ram #(.WIDTH(KW), .DEPTH(CHANNELS)) u_blog_ram (
      .clock   (clock),
      .wr_en   (blog_we),
      .wr_addr (idx_ff),
      .wr_data (blog_wd),
      .rd_addr (idx_ff),
      .rd_data (blog_rd)
   );

   // Decode of the current channel against the request.
   always_comb begin
      hit       = (CMP_W'(idx_ff) == CMP_W'(ch_ff));
      run_cur   = run_ff[idx_ff];
      skip_cur  = skip_ff[idx_ff];
      blog_cur  = bval_ff[idx_ff] ? blog_rd : '0;
      is_step   = (op_ff == ptb_pkg::OP_STEP);
      is_start  = (op_ff == ptb_pkg::OP_START) && hit;
      is_stop   = (op_ff == ptb_pkg::OP_STOP) && hit;
      is_poll   = (op_ff == ptb_pkg::OP_POLL) && hit;
      step_run  = is_step && run_cur;
      iv_eff    = (iv_ff == '0) ? TW'(1) : iv_ff;
      rem_sub   = {1'b0, rem_rd} - (skip_cur ? '0 : {1'b0, el_ff});
      rem_neg   = '0 - rem_sub;
      nonpos    = rem_sub[TW] || (rem_sub == '0);
      run_after = is_start ? 1'b1 : (is_stop ? 1'b0 : run_cur);
      rem_after = is_start ? iv_eff : (step_run ? rem_sub[TW-1:0] : rem_rd);
   end

   assign status.needs_div = step_run && nonpos;
   assign status.div_last  = (cnt_ff == ptb_pkg::DIV_CNT_W'(ptb_pkg::DIV_STEPS - 1));
   assign status.last_chan = (idx_ff == IDX_W'(CHANNELS - 1));

   // Divider step and the reload that follows it.
   always_comb begin
      div_trial = {r_ff[TW-1:0], q_ff[TW-1]};
      div_diff  = div_trial - {1'b0, d_ff};
      k_val     = {1'b0, q_ff} + (KW+1)'(1);
      tick_sum  = {2'b00, blog_hold_ff} + {1'b0, k_val};
      tick_sat  = (tick_sum > {2'b00, ptb_pkg::TICK_MAX}) ? ptb_pkg::TICK_MAX
                                                          : tick_sum[KW-1:0];
      rem_fix   = d_ff - r_ff[TW-1:0];
   end

   // Store writes.
   always_comb begin
      rem_we  = (cmd.eval && (is_start || (step_run && !nonpos))) || cmd.fix;
      rem_wd  = cmd.fix ? rem_fix : rem_after;
      per_we  = cmd.eval && is_start;
      per_wd  = iv_eff;
      blog_we = cmd.fix;
      blog_wd = tick_sat;
   end

   // Running minimum over running channels.
   always_comb begin
      min_en  = (cmd.eval && !status.needs_div && run_after) || cmd.fix;
      min_val = cmd.fix ? rem_fix : rem_after;
   end

   // Next values of the sweep state.
   always_comb begin
      op_in        = op_ff;
      ch_in        = ch_ff;
      iv_in        = iv_ff;
      el_in        = el_ff;
      idx_in       = idx_ff;
      run_in       = run_ff;
      skip_in      = skip_ff;
      bval_in      = bval_ff;
      due_in       = due_ff;
      any_in       = any_ff;
      best_in      = best_ff;
      drained_in   = drained_ff;
      chrun_in     = chrun_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      d_in         = d_ff;
      cnt_in       = cnt_ff;
      blog_hold_in = blog_hold_ff;

      // Capture of a new request.
      if (cmd.load) begin
         op_in      = ptb_pkg::ptb_op_type'(req_command);
         ch_in      = req_channel;
         iv_in      = req_interval_ms;
         el_in      = req_elapsed_ms;
         idx_in     = '0;
         due_in     = '0;
         any_in     = 1'b0;
         best_in    = '0;
         drained_in = '0;
         chrun_in   = 1'b0;
      end

      // Command effect on the current channel.
      if (cmd.eval) begin
         run_in[idx_ff] = run_after;
         if (is_start) begin
            skip_in[idx_ff] = 1'b1;
         end else if (step_run) begin
            skip_in[idx_ff] = 1'b0;
         end
         if (is_start || is_stop || is_poll) begin
            bval_in[idx_ff] = 1'b0;
         end
         if (is_poll) begin
            drained_in = blog_cur;
         end
         if (hit) begin
            chrun_in = run_after;
         end
         if (status.needs_div) begin
            q_in         = rem_neg[TW-1:0];
            r_in         = '0;
            d_in         = per_rd;
            cnt_in       = '0;
            blog_hold_in = blog_cur;
         end
      end

      // One restoring division step.
      if (cmd.div_step) begin
         if (!div_diff[TW]) begin
            r_in = div_diff;
            q_in = {q_ff[TW-2:0], 1'b1};
         end else begin
            r_in = div_trial;
            q_in = {q_ff[TW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
      end

      // Reload done: the channel is due.
      if (cmd.fix) begin
         bval_in[idx_ff] = 1'b1;
         due_in          = due_ff | (ptb_pkg::MASK_W'(1) << idx_ff);
      end

      if (min_en && (!any_ff || (min_val < best_ff))) begin
         best_in = min_val;
      end
      if (min_en) begin
         any_in = 1'b1;
      end

      if (cmd.advance) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= '0;
         skip_ff <= '0;
         bval_ff <= '0;
         idx_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         skip_ff <= skip_in;
         bval_ff <= bval_in;
         idx_ff  <= idx_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      ch_ff        <= ch_in;
      iv_ff        <= iv_in;
      el_ff        <= el_in;
      due_ff       <= due_in;
      any_ff       <= any_in;
      best_ff      <= best_in;
      drained_ff   <= drained_in;
      chrun_ff     <= chrun_in;
      q_ff         <= q_in;
      r_ff         <= r_in;
      d_ff         <= d_in;
      cnt_ff       <= cnt_in;
      blog_hold_ff <= blog_hold_in;
      if (cmd.finish) begin
         o_due_ff   <= due_ff;
         o_delay_ff <= any_ff ? best_ff : '0;
         o_nodl_ff  <= !any_ff;
         o_ticks_ff <= drained_ff;
         o_run_ff   <= chrun_ff;
      end
   end

   assign rsp_due_mask        = o_due_ff;
   assign rsp_next_delay_ms   = o_delay_ff;
   assign rsp_no_deadline     = o_nodl_ff;
   assign rsp_pending_ticks   = o_ticks_ff;
   assign rsp_channel_running = o_run_ff;

   // A running channel always keeps a positive remaining time.
   assert property (@(posedge clock) disable iff (reset)
      rem_we |-> rem_wd != '0)
      else $error("remaining time written as zero");

   // The divisor is a stored interval and never zero.
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> d_ff != '0)
      else $error("division by zero interval");

   // After the last step the remainder is below the interval.
   assert property (@(posedge clock) disable iff (reset)
      cmd.fix |-> r_ff < {1'b0, d_ff})
      else $error("divider remainder out of range");

endmodule

// ===== rtl/core/periodic_timer_bank.sv =====
// Top level of the periodic timer bank.
`timescale 1ns / 1ps

// Periodic timer bank: CHANNELS interval timers driven by time-step, start, stop
// and poll commands, one response per command. The controller sweeps every
// channel for every command (store read, then update), and a channel that comes
// due in a time step adds a pass of its serial divider, which finds the tick count
// in one quotient bit per cycle. A new command is taken while the previous
// response still waits for transfer.
module periodic_timer_bank #(
   parameter int CHANNELS = ptb_pkg::CHANNELS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   ptb_req_if.sink    req_bus,
   ptb_rsp_if.source  rsp_bus
);

   ptb_pkg::ptb_cmd_type    cmd;
   ptb_pkg::ptb_status_type status;

   ptb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ptb_dp #(.CHANNELS(CHANNELS)) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_command         (req_bus.command),
      .req_channel         (req_bus.channel),
      .req_interval_ms     (req_bus.interval_ms),
      .req_elapsed_ms      (req_bus.elapsed_ms),
      .rsp_due_mask        (rsp_bus.due_mask),
      .rsp_next_delay_ms   (rsp_bus.next_delay_ms),
      .rsp_no_deadline     (rsp_bus.no_deadline),
      .rsp_pending_ticks   (rsp_bus.pending_ticks),
      .rsp_channel_running (rsp_bus.channel_running)
   );

endmodule
